// ----- design/hsfd_pkg.sv -----
`default_nettype none

package hsfd_pkg;

    // Field widths
    localparam int BYTE_W = 8;
    localparam int TEMP_W = 15;
    localparam int HUMI_W = 14;
    localparam int CNT_W  = 16;
    localparam int CFG_AW = 2;

    // Result tdata: temperature, humidity, good_count from bit 0 up, padded to bytes
    localparam int OUT_W  = 48;
    localparam int PAD_W  = OUT_W - TEMP_W - HUMI_W - CNT_W;

    // Configuration register indexes
    localparam logic [CFG_AW-1:0] CFG_SENSOR_KIND = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_TEMP_OFFSET = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_HUMI_OFFSET = 2'd2;

    // CRC-8, polynomial x^8+x^5+x^4+1, seed all ones
    localparam logic [7:0] CRC_POLY = 8'h31;
    localparam logic [7:0] CRC_INIT = 8'hFF;
    localparam logic [15:0] TEMP_INVALID = 16'hFFFF;

    // Conversion constants
    localparam logic [14:0] TEMP_SCALE    = 15'd17500;
    localparam logic [15:0] TEMP_BASE     = 16'd4500;
    localparam logic [13:0] HUMI_SCALE_A  = 14'd10000;
    localparam logic [13:0] HUMI_SCALE_B  = 14'd12500;
    localparam logic [15:0] HUMI_BASE_B   = 16'd600;
    localparam logic [13:0] HUMI_MAX      = 14'd9999;

    // Byte position inside the five-byte reply
    typedef enum logic [4:0] {
        POS_T_HI = 5'b00001,
        POS_T_LO = 5'b00010,
        POS_CRC  = 5'b00100,
        POS_H_HI = 5'b01000,
        POS_H_LO = 5'b10000
    } pos_t;

    // Shift one byte through the CRC register, MSB first
    function automatic logic [7:0] crc8_byte(input logic [7:0] c_in);
        logic [7:0] c;
        c = c_in;
        for (int k = 0; k < 8; k++)
        begin
            if (c[7])
                c = {c[6:0], 1'b0} ^ CRC_POLY;
            else
                c = {c[6:0], 1'b0};
        end
        return c;
    endfunction

    // Offset in 0.1 steps to 0.01 steps: v*10 = v*8 + v*2
    function automatic logic signed [11:0] scale10(input logic signed [7:0] v);
        logic signed [11:0] ext;
        ext = {{4{v[7]}}, v};
        return (ext <<< 3) + (ext <<< 1);
    endfunction

endpackage

`default_nettype wire

// ----- design/humidity_sensor_frame_decoder_unit.sv -----
`default_nettype none

// Decodes the five-byte reply of a humidity/temperature sensor (temperature
// high, temperature low, CRC, humidity high, humidity low), one byte per
// s_axis transaction. frame_start (s_axis_tuser) restarts a frame. After
// the fifth byte one result transaction leaves on m_axis: frame_ok in
// tuser, plus the last good temperature (0.01 C, signed), humidity
// (0.01 %, clamped to 0..9999) and the wrapping good-frame count. The CRC
// (poly 0x31, init 0xFF) covers the temperature bytes; raw temperature
// 0xFFFF is rejected. The block takes one byte per clock; only the fifth
// byte waits on a stalled result port. A byte is processed while it sits
// in the input register and the result register loads at the next edge,
// so m_axis_tvalid is registered from the processed fifth byte.
// Configuration writes (cfg_we/cfg_addr/cfg_wdata) take effect at once and
// should be made while no frame is in flight.
module humidity_sensor_frame_decoder_unit
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,

    input  wire logic                          cfg_we,
    input  wire logic [hsfd_pkg::CFG_AW-1:0]   cfg_addr,
    input  wire logic [hsfd_pkg::BYTE_W-1:0]   cfg_wdata,

    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    input  wire logic [hsfd_pkg::BYTE_W-1:0]   s_axis_tdata,   // rx_byte
    input  wire logic [0:0]                    s_axis_tuser,   // frame_start

    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    output logic [hsfd_pkg::OUT_W-1:0]         m_axis_tdata,   // temperature, humidity,
                                                               // good_count, zero pad
    output logic [0:0]                         m_axis_tuser    // frame_ok
);
    import hsfd_pkg::*;

    // Configuration registers
    logic                sensor_kind_reg;
    logic signed [7:0]   temp_offset_reg;
    logic signed [7:0]   humi_offset_reg;

    // Input register
    logic                in_valid_reg;
    logic [BYTE_W-1:0]   in_byte_reg;
    logic                in_start_reg;

    // Frame state
    pos_t                pos_reg, pos_next, pos_eff;
    logic [15:0]         raw_temp_reg, raw_temp_next;
    logic [7:0]          crc_reg, crc_next, crc_seed;
    logic [7:0]          rx_crc_reg, rx_crc_next;
    logic [7:0]          humi_hi_reg, humi_hi_next;

    // Result register
    logic [TEMP_W-1:0]   held_temp_reg, held_temp_next;
    logic [HUMI_W-1:0]   held_humi_reg, held_humi_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic                out_valid_reg, out_valid_next;
    logic                out_ok_reg, out_ok_next;

    // Control
    logic                emits, out_free, advance, frame_ok;

    // Conversion datapath
    logic [30:0]         temp_prod;
    logic [14:0]         temp_conv;
    logic signed [15:0]  temp_sum;
    logic [13:0]         humi_scale;
    logic [29:0]         humi_prod;
    logic [13:0]         humi_conv;
    logic signed [15:0]  humi_sum;
    logic signed [11:0]  temp_off10, humi_off10;
    logic [15:0]         raw_humi;

    // Configuration writes; unknown indexes are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_kind_reg <= 1'b0;
            temp_offset_reg <= '0;
            humi_offset_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_SENSOR_KIND: sensor_kind_reg <= cfg_wdata[0];
                CFG_TEMP_OFFSET: temp_offset_reg <= cfg_wdata;
                CFG_HUMI_OFFSET: humi_offset_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // Handshake control
    assign pos_eff       = in_start_reg ? POS_T_HI : pos_reg;
    assign emits         = (pos_eff == POS_H_LO);
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign advance       = in_valid_reg && (!emits || out_free);
    assign s_axis_tready = !in_valid_reg || advance;

    // Input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_axis_tready)
            in_valid_reg <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            in_byte_reg  <= s_axis_tdata;
            in_start_reg <= s_axis_tuser[0];
        end
    end

    // Frame check
    assign crc_seed = (pos_eff == POS_T_HI) ? CRC_INIT : crc_reg;
    assign frame_ok = (crc_reg == rx_crc_reg) && (raw_temp_reg != TEMP_INVALID);

    // Temperature conversion
    assign temp_off10 = scale10(temp_offset_reg);
    assign temp_prod  = 31'(raw_temp_reg) * 31'(TEMP_SCALE);
    assign temp_conv  = temp_prod[30:16];
    assign temp_sum   = signed'({1'b0, temp_conv}) - signed'(TEMP_BASE)
                        + 16'(temp_off10);

    // Humidity conversion, one multiplier shared by both sensor kinds
    assign raw_humi   = {humi_hi_reg, in_byte_reg};
    assign humi_off10 = scale10(humi_offset_reg);
    assign humi_scale = sensor_kind_reg ? HUMI_SCALE_B : HUMI_SCALE_A;
    assign humi_prod  = 30'(raw_humi) * 30'(humi_scale);
    assign humi_conv  = humi_prod[29:16];
    assign humi_sum   = signed'({2'b00, humi_conv})
                        - (sensor_kind_reg ? signed'(HUMI_BASE_B) : 16'sd0)
                        + 16'(humi_off10);

    // Next-state logic for one byte
    always_comb
    begin
        pos_next       = pos_reg;
        raw_temp_next  = raw_temp_reg;
        crc_next       = crc_reg;
        rx_crc_next    = rx_crc_reg;
        humi_hi_next   = humi_hi_reg;
        held_temp_next = held_temp_reg;
        held_humi_next = held_humi_reg;
        count_next     = count_reg;
        out_ok_next    = out_ok_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;

        if (advance)
        begin
            case (pos_eff)
                POS_T_HI:
                begin
                    raw_temp_next = {in_byte_reg, 8'h00};
                    crc_next      = crc8_byte(crc_seed ^ in_byte_reg);
                    pos_next      = POS_T_LO;
                end
                POS_T_LO:
                begin
                    raw_temp_next = {raw_temp_reg[15:8], in_byte_reg};
                    crc_next      = crc8_byte(crc_seed ^ in_byte_reg);
                    pos_next      = POS_CRC;
                end
                POS_CRC:
                begin
                    rx_crc_next = in_byte_reg;
                    pos_next    = POS_H_HI;
                end
                POS_H_HI:
                begin
                    humi_hi_next = in_byte_reg;
                    pos_next     = POS_H_LO;
                end
                POS_H_LO:
                begin
                    pos_next       = POS_T_HI;
                    crc_next       = CRC_INIT;
                    out_valid_next = 1'b1;
                    out_ok_next    = frame_ok;
                    if (frame_ok)
                    begin
                        held_temp_next = temp_sum[TEMP_W-1:0];
                        if (humi_sum < 16'sd0)
                            held_humi_next = '0;
                        else if (humi_sum > signed'({2'b00, HUMI_MAX}))
                            held_humi_next = HUMI_MAX;
                        else
                            held_humi_next = humi_sum[HUMI_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    pos_next = POS_T_HI;
                end
            endcase
        end
    end

    // State and result registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= POS_T_HI;
            raw_temp_reg  <= '0;
            crc_reg       <= CRC_INIT;
            rx_crc_reg    <= '0;
            humi_hi_reg   <= '0;
            held_temp_reg <= '0;
            held_humi_reg <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            out_ok_reg    <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            raw_temp_reg  <= raw_temp_next;
            crc_reg       <= crc_next;
            rx_crc_reg    <= rx_crc_next;
            humi_hi_reg   <= humi_hi_next;
            held_temp_reg <= held_temp_next;
            held_humi_reg <= held_humi_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            out_ok_reg    <= out_ok_next;
        end
    end

    // Held values only change when a result is issued, so they drive tdata
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_ok_reg;
    assign m_axis_tdata  = {{PAD_W{1'b0}}, count_reg, held_humi_reg, held_temp_reg};

endmodule

`default_nettype wire

// ----- design/hsfd_checker.sv -----
`default_nettype none

module hsfd_checker
(
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    input  wire logic [hsfd_pkg::OUT_W-1:0]    m_axis_tdata,   // temperature, humidity,
                                                               // good_count, zero pad
    input  wire logic [0:0]                    m_axis_tuser    // frame_ok
);
    import hsfd_pkg::*;

    localparam int DATA_W = TEMP_W + HUMI_W + CNT_W;

    logic                out_acc;
    logic                seen_reg;
    logic [DATA_W-1:0]   prev_data_reg;
    logic [CNT_W-1:0]    prev_count;
    logic [CNT_W-1:0]    cur_count;
    logic [HUMI_W-1:0]   cur_humi;

    assign out_acc    = m_axis_tvalid && m_axis_tready;
    assign prev_count = prev_data_reg[DATA_W-1 -: CNT_W];
    assign cur_count  = m_axis_tdata[DATA_W-1 -: CNT_W];
    assign cur_humi   = m_axis_tdata[TEMP_W +: HUMI_W];

    // Remember the last result transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            seen_reg <= 1'b0;
        else if (out_acc)
            seen_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (out_acc)
            prev_data_reg <= m_axis_tdata[DATA_W-1:0];
    end

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
                                            && $stable(m_axis_tuser))
        else $error("result changed while stalled");

    // Humidity always clamped
    a_humi_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> cur_humi <= HUMI_MAX)
        else $error("humidity above clamp");

    // Pad bits above the count stay zero
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[OUT_W-1:DATA_W] == '0)
        else $error("tdata pad not zero");

    // A good frame bumps the count by one
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg && m_axis_tuser[0] |-> cur_count == CNT_W'(prev_count + 1'b1))
        else $error("good_count did not advance by one");

    // A bad frame repeats the previous readings
    a_bad_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_acc && seen_reg && !m_axis_tuser[0] |-> m_axis_tdata[DATA_W-1:0] == prev_data_reg)
        else $error("bad frame changed held readings");

endmodule

bind humidity_sensor_frame_decoder_unit hsfd_checker u_hsfd_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
